// ===== design/sfg_pkg.sv =====
`default_nettype none
package sfg_pkg;

  // field widths
  localparam int unsigned DIST_W     = 16;
  localparam int unsigned ERR_W      = 16;
  localparam int unsigned GAIN_W     = 14;

  // membership arithmetic
  localparam int unsigned TERMS       = 3;
  localparam int unsigned SETS        = 2;
  localparam int unsigned XD_W        = 23;
  localparam int unsigned DIST_SCALE  = 100;
  localparam int unsigned NUM_W       = 22;
  localparam int unsigned RECIP_W     = 27;
  localparam int unsigned RECIP_SHIFT = 28;
  localparam int unsigned PROD_W      = NUM_W + RECIP_W;
  localparam int unsigned MU_W        = 17;
  localparam logic [MU_W-1:0] MU_ONE  = MU_W'(65536);

  // rule evaluation and weighted mean
  localparam int unsigned RULE_SLOTS = 16;
  localparam int unsigned S10_W      = 5;
  localparam int unsigned WS_W       = MU_W + S10_W;
  localparam int unsigned SUMW_W     = 21;
  localparam int unsigned SUMWS_W    = 25;
  localparam int unsigned S10_SCALE  = 10;
  localparam int unsigned GAIN_SHIFT = 13;
  localparam int unsigned DIV_NUM_W  = 39;
  localparam int unsigned DIV_DEN_W  = 26;
  localparam int unsigned DIV_STAGES = GAIN_W;

  // queue between front and back
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    RULE_UNUSED = 2'd0,
    RULE_DIST   = 2'd1,
    RULE_BOTH   = 2'd2
  } rule_kind_e;

  typedef struct packed {
    rule_kind_e        kind;
    logic [1:0]        dterm;
    logic [1:0]        eterm;
    logic [S10_W-1:0]  s10;
  } rule_t;

  // one membership term after classification
  typedef struct packed {
    logic               zero;
    logic               one;
    logic [NUM_W-1:0]   num;
    logic [RECIP_W-1:0] recip;
  } term_t;

  typedef struct packed {
    logic                  cmd;
    term_t [TERMS-1:0]     dist_term;
    term_t [TERMS-1:0]     err;
  } item_t;

  // distance breakpoints in units of 1/409600 m (set 0 gate, set 1 docking)
  localparam logic [XD_W-1:0] DIST_BP [SETS][TERMS][4] = '{
    '{ '{XD_W'(0 * 4096),  XD_W'(0 * 4096),  XD_W'(20 * 4096),  XD_W'(40 * 4096)},
       '{XD_W'(30 * 4096), XD_W'(50 * 4096), XD_W'(70 * 4096),  XD_W'(80 * 4096)},
       '{XD_W'(70 * 4096), XD_W'(80 * 4096), XD_W'(100 * 4096), XD_W'(100 * 4096)} },
    '{ '{XD_W'(5 * 4096),  XD_W'(8 * 4096),  XD_W'(12 * 4096),  XD_W'(15 * 4096)},
       '{XD_W'(13 * 4096), XD_W'(18 * 4096), XD_W'(25 * 4096),  XD_W'(35 * 4096)},
       '{XD_W'(30 * 4096), XD_W'(40 * 4096), XD_W'(100 * 4096), XD_W'(100 * 4096)} }
  };

  // error breakpoints in 1/32 pixel units
  localparam logic signed [ERR_W-1:0] ERR_BP [SETS][TERMS][4] = '{
    '{ '{ERR_W'(0 * 32),   ERR_W'(0 * 32),   ERR_W'(20 * 32),  ERR_W'(40 * 32)},
       '{ERR_W'(30 * 32),  ERR_W'(60 * 32),  ERR_W'(100 * 32), ERR_W'(130 * 32)},
       '{ERR_W'(110 * 32), ERR_W'(150 * 32), ERR_W'(320 * 32), ERR_W'(320 * 32)} },
    '{ '{ERR_W'(0 * 32),   ERR_W'(0 * 32),   ERR_W'(15 * 32),  ERR_W'(30 * 32)},
       '{ERR_W'(25 * 32),  ERR_W'(50 * 32),  ERR_W'(80 * 32),  ERR_W'(100 * 32)},
       '{ERR_W'(90 * 32),  ERR_W'(120 * 32), ERR_W'(320 * 32), ERR_W'(320 * 32)} }
  };

  // ceil(2^28 / span) per slope; span in hundredths of a metre or pixels,
  // flat shoulders carry a dummy span of one
  localparam logic [RECIP_W-1:0] DIST_RISE_M [SETS][TERMS] = '{
    '{RECIP_W'((2**28 + 1 - 1) / 1),  RECIP_W'((2**28 + 20 - 1) / 20),
      RECIP_W'((2**28 + 10 - 1) / 10)},
    '{RECIP_W'((2**28 + 3 - 1) / 3),  RECIP_W'((2**28 + 5 - 1) / 5),
      RECIP_W'((2**28 + 10 - 1) / 10)}
  };
  localparam logic [RECIP_W-1:0] DIST_FALL_M [SETS][TERMS] = '{
    '{RECIP_W'((2**28 + 20 - 1) / 20), RECIP_W'((2**28 + 10 - 1) / 10),
      RECIP_W'((2**28 + 1 - 1) / 1)},
    '{RECIP_W'((2**28 + 3 - 1) / 3),   RECIP_W'((2**28 + 10 - 1) / 10),
      RECIP_W'((2**28 + 1 - 1) / 1)}
  };
  localparam logic [RECIP_W-1:0] ERR_RISE_M [SETS][TERMS] = '{
    '{RECIP_W'((2**28 + 1 - 1) / 1),  RECIP_W'((2**28 + 30 - 1) / 30),
      RECIP_W'((2**28 + 40 - 1) / 40)},
    '{RECIP_W'((2**28 + 1 - 1) / 1),  RECIP_W'((2**28 + 25 - 1) / 25),
      RECIP_W'((2**28 + 30 - 1) / 30)}
  };
  localparam logic [RECIP_W-1:0] ERR_FALL_M [SETS][TERMS] = '{
    '{RECIP_W'((2**28 + 20 - 1) / 20), RECIP_W'((2**28 + 30 - 1) / 30),
      RECIP_W'((2**28 + 1 - 1) / 1)},
    '{RECIP_W'((2**28 + 15 - 1) / 15), RECIP_W'((2**28 + 20 - 1) / 20),
      RECIP_W'((2**28 + 1 - 1) / 1)}
  };

  // rule tables, singletons in tenths
  localparam rule_t RULES [SETS][RULE_SLOTS] = '{
    '{ '{RULE_BOTH, 2'd0, 2'd0, 5'd10}, '{RULE_BOTH, 2'd0, 2'd1, 5'd19},
       '{RULE_BOTH, 2'd0, 2'd2, 5'd25}, '{RULE_BOTH, 2'd1, 2'd0, 5'd10},
       '{RULE_BOTH, 2'd1, 2'd1, 5'd19}, '{RULE_BOTH, 2'd1, 2'd2, 5'd25},
       '{RULE_BOTH, 2'd2, 2'd0, 5'd19}, '{RULE_BOTH, 2'd2, 2'd1, 5'd25},
       '{RULE_BOTH, 2'd2, 2'd2, 5'd25}, '{RULE_UNUSED, 2'd0, 2'd0, 5'd0},
       '{RULE_UNUSED, 2'd0, 2'd0, 5'd0}, '{RULE_UNUSED, 2'd0, 2'd0, 5'd0},
       '{RULE_UNUSED, 2'd0, 2'd0, 5'd0}, '{RULE_UNUSED, 2'd0, 2'd0, 5'd0},
       '{RULE_UNUSED, 2'd0, 2'd0, 5'd0}, '{RULE_UNUSED, 2'd0, 2'd0, 5'd0} },
    '{ '{RULE_DIST, 2'd0, 2'd0, 5'd5},  '{RULE_BOTH, 2'd1, 2'd0, 5'd5},
       '{RULE_BOTH, 2'd1, 2'd1, 5'd12}, '{RULE_BOTH, 2'd1, 2'd2, 5'd19},
       '{RULE_BOTH, 2'd2, 2'd0, 5'd12}, '{RULE_BOTH, 2'd2, 2'd1, 5'd19},
       '{RULE_BOTH, 2'd2, 2'd2, 5'd19}, '{RULE_UNUSED, 2'd0, 2'd0, 5'd0},
       '{RULE_UNUSED, 2'd0, 2'd0, 5'd0}, '{RULE_UNUSED, 2'd0, 2'd0, 5'd0},
       '{RULE_UNUSED, 2'd0, 2'd0, 5'd0}, '{RULE_UNUSED, 2'd0, 2'd0, 5'd0},
       '{RULE_UNUSED, 2'd0, 2'd0, 5'd0}, '{RULE_UNUSED, 2'd0, 2'd0, 5'd0},
       '{RULE_UNUSED, 2'd0, 2'd0, 5'd0}, '{RULE_UNUSED, 2'd0, 2'd0, 5'd0} }
  };

endpackage
`default_nettype wire

// ===== design/sfg_front.sv =====
`default_nettype none
module sfg_front import sfg_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    push_i,
  output logic                         full_o,
  input  wire logic                    command_i,
  input  wire logic [DIST_W-1:0]       distance_i,
  input  wire logic signed [ERR_W-1:0] pixel_error_i,
  input  wire logic                    fifo_full_i,
  output logic                         item_valid_o,
  output item_t                        item_o
);

  logic  valid_q;
  item_t item_q;
  item_t item_d;

  // classify each trapezoid: outside, rising slope, plateau, falling slope
  always_comb begin
    logic [XD_W-1:0]         xd;
    logic [XD_W-1:0]         doff;
    logic signed [ERR_W-1:0] eoff;
    xd     = XD_W'(distance_i) * XD_W'(DIST_SCALE);
    doff   = '0;
    eoff   = '0;
    item_d = '0;
    item_d.cmd = command_i;
    for (int t = 0; t < TERMS; t++) begin
      if (xd < DIST_BP[command_i][t][0] || xd > DIST_BP[command_i][t][3]) begin
        item_d.dist_term[t].zero = 1'b1;
      end else if (xd < DIST_BP[command_i][t][1]) begin
        doff = xd - DIST_BP[command_i][t][0];
        item_d.dist_term[t].num   = NUM_W'({doff[16:0], 4'b0000});
        item_d.dist_term[t].recip = DIST_RISE_M[command_i][t];
      end else if (xd <= DIST_BP[command_i][t][2]) begin
        item_d.dist_term[t].one = 1'b1;
      end else begin
        doff = DIST_BP[command_i][t][3] - xd;
        item_d.dist_term[t].num   = NUM_W'({doff[16:0], 4'b0000});
        item_d.dist_term[t].recip = DIST_FALL_M[command_i][t];
      end

      if (pixel_error_i < ERR_BP[command_i][t][0] ||
          pixel_error_i > ERR_BP[command_i][t][3]) begin
        item_d.err[t].zero = 1'b1;
      end else if (pixel_error_i < ERR_BP[command_i][t][1]) begin
        eoff = pixel_error_i - ERR_BP[command_i][t][0];
        item_d.err[t].num   = NUM_W'({eoff[10:0], 11'b0});
        item_d.err[t].recip = ERR_RISE_M[command_i][t];
      end else if (pixel_error_i <= ERR_BP[command_i][t][2]) begin
        item_d.err[t].one = 1'b1;
      end else begin
        eoff = ERR_BP[command_i][t][3] - pixel_error_i;
        item_d.err[t].num   = NUM_W'({eoff[10:0], 11'b0});
        item_d.err[t].recip = ERR_FALL_M[command_i][t];
      end
    end
  end

  assign full_o       = valid_q & fifo_full_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  // input stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!full_o) begin
      valid_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!full_o) begin
      item_q <= item_d;
    end
  end

endmodule
`default_nettype wire

// ===== design/sfg_fifo.sv =====
`default_nettype none
module sfg_fifo import sfg_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t item_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output logic       empty_o,
  output item_t      item_o
);

  item_t                 mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q;
  logic [FIFO_PTR_W-1:0] rd_ptr_q;
  logic [FIFO_CNT_W-1:0] count_q;
  logic                  do_push;
  logic                  do_pop;

  assign full_o  = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign item_o  = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/sfg_div.sv =====
`default_nettype none
module sfg_div import sfg_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 valid_i,
  input  wire logic [DIV_NUM_W-1:0] num_i,
  input  wire logic [DIV_DEN_W-1:0] den_i,
  input  wire logic                 zero_i,
  output logic                      valid_o,
  output logic [GAIN_W-1:0]         quot_o,
  output logic                      zero_o
);

  logic                 v_q   [DIV_STAGES];
  logic [DIV_NUM_W-1:0] rem_q [DIV_STAGES];
  logic [DIV_DEN_W-1:0] den_q [DIV_STAGES];
  logic [GAIN_W-1:0]    quo_q [DIV_STAGES];
  logic                 z_q   [DIV_STAGES];

  // one quotient bit per stage, most significant first
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    localparam int unsigned BIT = DIV_STAGES - 1 - s;
    logic                 v_in;
    logic [DIV_NUM_W-1:0] rem_in;
    logic [DIV_DEN_W-1:0] den_in;
    logic [GAIN_W-1:0]    quo_in;
    logic                 z_in;
    logic [DIV_NUM_W-1:0] dsh;
    logic                 ge;

    if (s == 0) begin : g_first
      assign v_in   = valid_i;
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
      assign z_in   = zero_i;
    end else begin : g_next
      assign v_in   = v_q[s-1];
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
      assign z_in   = z_q[s-1];
    end

    assign dsh = DIV_NUM_W'(den_in) << BIT;
    assign ge  = (rem_in >= dsh);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= ge ? rem_in - dsh : rem_in;
        den_q[s] <= den_in;
        quo_q[s] <= ge ? (quo_in | (GAIN_W'(1) << BIT)) : quo_in;
        z_q[s]   <= z_in;
      end
    end
  end

  assign valid_o = v_q[DIV_STAGES-1];
  assign quot_o  = quo_q[DIV_STAGES-1];
  assign zero_o  = z_q[DIV_STAGES-1];

endmodule
`default_nettype wire

// ===== design/sfg_back.sv =====
`default_nettype none
module sfg_back import sfg_pkg::*; #(
  parameter int GATE_RULE_COUNT = 9,
  parameter int DOCK_RULE_COUNT = 7
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          fifo_empty_i,
  input  wire item_t         item_i,
  output logic               fifo_pop_o,
  output logic               empty_o,
  input  wire logic          pop_i,
  output logic [GAIN_W-1:0]  gain_o,
  output logic               no_rule_fired_o
);

  logic                 en;
  logic                 div_valid;
  logic [GAIN_W-1:0]    div_quot;
  logic                 div_zero;

  logic                 v1_q;
  logic                 cmd1_q;
  logic [MU_W-1:0]      mu_d_q [TERMS];
  logic [MU_W-1:0]      mu_e_q [TERMS];
  logic [MU_W-1:0]      mu_d_d [TERMS];
  logic [MU_W-1:0]      mu_e_d [TERMS];

  logic                 v2_q;
  logic [MU_W-1:0]      w_q  [RULE_SLOTS];
  logic [WS_W-1:0]      ws_q [RULE_SLOTS];
  logic [MU_W-1:0]      w_d  [RULE_SLOTS];
  logic [WS_W-1:0]      ws_d [RULE_SLOTS];

  logic                 v3_q;
  logic [SUMW_W-1:0]    sumw_q;
  logic [SUMWS_W-1:0]   sumws_q;
  logic [SUMW_W-1:0]    sumw_d;
  logic [SUMWS_W-1:0]   sumws_d;

  logic                 v4_q;
  logic [DIV_NUM_W-1:0] num_q;
  logic [DIV_DEN_W-1:0] den_q;
  logic                 zero_q;

  // whole back pipeline moves unless the output beat is held
  assign en         = ~div_valid | pop_i;
  assign fifo_pop_o = en & ~fifo_empty_i;

  // memberships: offset times reciprocal of the span
  always_comb begin
    logic [PROD_W-1:0] pd;
    logic [PROD_W-1:0] pe;
    for (int t = 0; t < TERMS; t++) begin
      pd = PROD_W'(item_i.dist_term[t].num) * PROD_W'(item_i.dist_term[t].recip);
      pe = PROD_W'(item_i.err[t].num) * PROD_W'(item_i.err[t].recip);
      if (item_i.dist_term[t].zero) begin
        mu_d_d[t] = '0;
      end else if (item_i.dist_term[t].one) begin
        mu_d_d[t] = MU_ONE;
      end else begin
        mu_d_d[t] = MU_W'(pd[RECIP_SHIFT +: 16]);
      end
      if (item_i.err[t].zero) begin
        mu_e_d[t] = '0;
      end else if (item_i.err[t].one) begin
        mu_e_d[t] = MU_ONE;
      end else begin
        mu_e_d[t] = MU_W'(pe[RECIP_SHIFT +: 16]);
      end
    end
  end

  // rule strengths and weighted singletons
  always_comb begin
    rule_t           r;
    logic [MU_W-1:0] w;
    logic            active;
    for (int i = 0; i < RULE_SLOTS; i++) begin
      r      = RULES[cmd1_q][i];
      active = (r.kind != RULE_UNUSED) &&
               (cmd1_q ? (i < DOCK_RULE_COUNT) : (i < GATE_RULE_COUNT));
      w      = mu_d_q[r.dterm];
      if (r.kind == RULE_BOTH && mu_e_q[r.eterm] < w) begin
        w = mu_e_q[r.eterm];
      end
      if (!active) begin
        w = '0;
      end
      w_d[i]  = w;
      ws_d[i] = WS_W'(w) * WS_W'(r.s10);
    end
  end

  // strength sums
  always_comb begin
    sumw_d  = '0;
    sumws_d = '0;
    for (int i = 0; i < RULE_SLOTS; i++) begin
      sumw_d  = sumw_d + SUMW_W'(w_q[i]);
      sumws_d = sumws_d + SUMWS_W'(ws_q[i]);
    end
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= ~fifo_empty_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd1_q  <= item_i.cmd;
      mu_d_q  <= mu_d_d;
      mu_e_q  <= mu_e_d;
      w_q     <= w_d;
      ws_q    <= ws_d;
      sumw_q  <= sumw_d;
      sumws_q <= sumws_d;
      // rounded mean: (sws*8192 + 10*sw) / (20*sw)
      num_q   <= (DIV_NUM_W'(sumws_q) << GAIN_SHIFT) +
                 DIV_NUM_W'(sumw_q) * DIV_NUM_W'(S10_SCALE);
      den_q   <= DIV_DEN_W'(sumw_q) * DIV_DEN_W'(2 * S10_SCALE);
      zero_q  <= (sumw_q == '0);
    end
  end

  sfg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v4_q),
    .num_i   (num_q),
    .den_i   (den_q),
    .zero_i  (zero_q),
    .valid_o (div_valid),
    .quot_o  (div_quot),
    .zero_o  (div_zero)
  );

  assign empty_o         = ~div_valid;
  assign gain_o          = div_zero ? '0 : div_quot;
  assign no_rule_fired_o = div_zero;

endmodule
`default_nettype wire

// ===== design/sugeno_fuzzy_gain_top.sv =====
// Zero-order Sugeno gain scheduler. Each input beat (command, distance,
// pixel_error) yields exactly one result beat (gain, no_rule_fired).
// Input channel: drive push with the fields; the beat is taken on a clock
// edge where push is high and full is low.
// Result channel: while empty is low the oldest result sits on gain_o and
// no_rule_fired_o; it is taken on an edge where pop is high.
// Throughput: one beat per cycle in both directions while full stays low
// and results are popped. Path from the input edge until empty drops:
// input register, queue, membership multiply, rule min, sums, mean setup
// and a 14-stage one-bit-per-stage divider for the weighted mean.
// Stall: when the result is not popped the back pipeline freezes; the front
// keeps taking beats into a four-entry queue, and full rises only once
// that queue and the input register are both occupied.
// Reset: asynchronous, active low; all in-flight beats are dropped and
// both channels come up empty.
`default_nettype none
module sugeno_fuzzy_gain_top import sfg_pkg::*; #(
  parameter int GATE_RULE_COUNT = 9,
  parameter int DOCK_RULE_COUNT = 7
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    push,
  output logic                         full,
  input  wire logic                    command_i,
  input  wire logic [DIST_W-1:0]       distance_i,
  input  wire logic signed [ERR_W-1:0] pixel_error_i,
  output logic                         empty,
  input  wire logic                    pop,
  output logic [GAIN_W-1:0]            gain_o,
  output logic                         no_rule_fired_o
);

  logic  front_valid;
  item_t front_item;
  logic  fifo_full;
  logic  fifo_empty;
  logic  fifo_pop;
  item_t fifo_item;

  sfg_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .command_i     (command_i),
    .distance_i    (distance_i),
    .pixel_error_i (pixel_error_i),
    .fifo_full_i   (fifo_full),
    .item_valid_o  (front_valid),
    .item_o        (front_item)
  );

  sfg_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .item_i  (front_item),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .empty_o (fifo_empty),
    .item_o  (fifo_item)
  );

  sfg_back #(
    .GATE_RULE_COUNT (GATE_RULE_COUNT),
    .DOCK_RULE_COUNT (DOCK_RULE_COUNT)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fifo_empty_i    (fifo_empty),
    .item_i          (fifo_item),
    .fifo_pop_o      (fifo_pop),
    .empty_o         (empty),
    .pop_i           (pop),
    .gain_o          (gain_o),
    .no_rule_fired_o (no_rule_fired_o)
  );

endmodule
`default_nettype wire

// ===== sim/sfg_checker.sv =====
`timescale 1ns / 100ps
`default_nettype none
module sfg_checker import sfg_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    push,
  input  wire logic                    full,
  input  wire logic                    command_i,
  input  wire logic [DIST_W-1:0]       distance_i,
  input  wire logic signed [ERR_W-1:0] pixel_error_i,
  input  wire logic                    empty,
  input  wire logic                    pop,
  input  wire logic [GAIN_W-1:0]       gain_o,
  input  wire logic                    no_rule_fired_o,
  output int                           fail_cnt_o,
  output int                           pending_o
);

  typedef struct {
    logic [GAIN_W-1:0] gain;
    logic              no_rule;
  } gain_beat_t;

  gain_beat_t gain_q[$];

  assign pending_o = gain_q.size();

  // trapezoid membership in q1.16 (one = 65536), breakpoints given as plain integers
  function automatic longint trap_mu(longint x, longint a, longint b, longint c, longint d);
    if (x < a || x > d) return 0;
    if (x < b) return ((x - a) * 65536) / (b - a);
    if (x <= c) return 65536;
    if (d > c) return ((d - x) * 65536) / (d - c);
    return 65536;
  endfunction

  // weighted singleton mean for one beat
  function automatic gain_beat_t fuzzy_gain(logic dock, logic [15:0] dval,
                                            logic signed [15:0] perr);
    gain_beat_t r;
    longint xd, xe, w, we, sw, sws, den;
    // breakpoints in hundredths of a metre and in pixels
    int dbp[2][3][4] = '{
      '{'{0, 0, 20, 40}, '{30, 50, 70, 80}, '{70, 80, 100, 100}},
      '{'{5, 8, 12, 15}, '{13, 18, 25, 35}, '{30, 40, 100, 100}}};
    int ebp[2][3][4] = '{
      '{'{0, 0, 20, 40}, '{30, 60, 100, 130}, '{110, 150, 320, 320}},
      '{'{0, 0, 15, 30}, '{25, 50, 80, 100}, '{90, 120, 320, 320}}};
    int kind[2][9] = '{'{2, 2, 2, 2, 2, 2, 2, 2, 2}, '{1, 2, 2, 2, 2, 2, 2, 0, 0}};
    int dt[2][9] = '{'{0, 0, 0, 1, 1, 1, 2, 2, 2}, '{0, 1, 1, 1, 2, 2, 2, 0, 0}};
    int et[2][9] = '{'{0, 1, 2, 0, 1, 2, 0, 1, 2}, '{0, 0, 1, 2, 0, 1, 2, 0, 0}};
    int sv[2][9] = '{'{10, 19, 25, 10, 19, 25, 19, 25, 25},
                     '{5, 5, 12, 19, 12, 19, 19, 0, 0}};
    int s;
    s = dock;
    xd = longint'(dval) * 100;
    xe = longint'(perr);
    sw = 0;
    sws = 0;
    for (int i = 0; i < 9; i++) begin
      if (kind[s][i] != 0) begin
        w = trap_mu(xd, dbp[s][dt[s][i]][0] * 4096, dbp[s][dt[s][i]][1] * 4096,
                    dbp[s][dt[s][i]][2] * 4096, dbp[s][dt[s][i]][3] * 4096);
        if (kind[s][i] == 2) begin
          we = trap_mu(xe, ebp[s][et[s][i]][0] * 32, ebp[s][et[s][i]][1] * 32,
                       ebp[s][et[s][i]][2] * 32, ebp[s][et[s][i]][3] * 32);
          if (we < w) w = we;
        end
        sw += w;
        sws += w * sv[s][i];
      end
    end
    if (sw == 0) begin
      r.gain = '0;
      r.no_rule = 1'b1;
    end else begin
      den = sw * 10;
      r.gain = GAIN_W'((sws * 8192 + den) / (2 * den));
      r.no_rule = 1'b0;
    end
    return r;
  endfunction

  // predict on input beats, compare on result beats
  always @(posedge clk_i or negedge rst_ni) begin
    gain_beat_t exp_b;
    if (!rst_ni) begin
      fail_cnt_o <= 0;
    end else begin
      if (push && !full) gain_q.push_back(fuzzy_gain(command_i, distance_i, pixel_error_i));
      if (pop && !empty) begin
        if (gain_q.size() == 0) begin
          $error("result beat with nothing expected");
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          exp_b = gain_q.pop_front();
          if (gain_o !== exp_b.gain || no_rule_fired_o !== exp_b.no_rule) begin
            if (gain_o !== exp_b.gain)
              $error("gain expected %0d actual %0d", exp_b.gain, gain_o);
            if (no_rule_fired_o !== exp_b.no_rule)
              $error("no_rule_fired expected %0d actual %0d", exp_b.no_rule,
                     no_rule_fired_o);
            fail_cnt_o <= fail_cnt_o + 1;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import sfg_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic command_i = 1'b0;
  logic [DIST_W-1:0] distance_i = '0;
  logic signed [ERR_W-1:0] pixel_error_i = '0;
  logic full, empty, no_rule_fired_o;
  logic [GAIN_W-1:0] gain_o;
  int fail_cnt, pending;
  int cycle_cnt = 0;
  bit quiet = 1'b0;

  always #5 clk_i = ~clk_i;

  sugeno_fuzzy_gain_top u_dut (.*);

  sfg_checker u_chk (.*, .fail_cnt_o(fail_cnt), .pending_o(pending));

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 200000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side pops at random, and on every cycle while quiet is set
  always @(negedge clk_i) begin
    pop <= quiet ? 1'b1 : ($urandom_range(99) >= 19);
  end

  // one beat, held until taken
  task automatic send_beat(logic c, logic [15:0] d, logic [15:0] e);
    while (!quiet && $urandom_range(99) < 19) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    command_i <= c;
    distance_i <= d;
    pixel_error_i <= e;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // distance in hundredths of a metre to q4.12
  function automatic logic [15:0] dist_q(int h);
    return 16'((h * 4096) / 100);
  endfunction

  initial begin
    logic [15:0] d, e;
    int k;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // directed: field extremes, both sets, shoulders, negative error
    for (int c = 0; c < 2; c++) begin
      send_beat(1'(c), 16'h0000, 16'h0000);
      send_beat(1'(c), 16'hffff, 16'h7fff);
      send_beat(1'(c), 16'h0000, 16'h8000);
      send_beat(1'(c), 16'h7fff, 16'hffff);
      send_beat(1'(c), dist_q(100), 16'(320 * 32));
      send_beat(1'(c), dist_q(50), 16'(60 * 32));
      send_beat(1'(c), dist_q(10), 16'(10 * 32));
      send_beat(1'(c), dist_q(75), 16'(140 * 32));
      send_beat(1'(c), dist_q(20), 16'(20 * 32));
      send_beat(1'(c), dist_q(30), 16'(321 * 32));
      send_beat(1'(c), 16'h5555, 16'haaaa);
    end
    // random: mostly inside the universes, some anywhere
    for (int i = 0; i < 1700; i++) begin
      quiet = (i >= 600 && i < 800);
      k = $urandom_range(9);
      if (k < 7) begin
        d = 16'($urandom_range(4400));
        e = 16'($urandom_range(10400));
        if (k == 0) e = -e;
      end else begin
        d = 16'($urandom);
        e = 16'($urandom);
      end
      send_beat(1'($urandom_range(1)), d, e);
    end
    push <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
    if (fail_cnt == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
`default_nettype wire
